/* rtl/sscfe_pkg.sv */
// sscfe_pkg: shared types, constants and crc-8 helpers for the framed spi slave
// used by sscfe_ctrl, sscfe_datapath and spi_slave_crc8_frame_exchange
`timescale 1ns / 1ps
`default_nettype none

package sscfe_pkg;

  localparam int PAYLOAD_BYTES = 12;
  localparam int FRAME_BYTES   = 14;

  localparam int STEP_MAX  = (FRAME_BYTES > PAYLOAD_BYTES) ? FRAME_BYTES : PAYLOAD_BYTES;
  localparam int STEP_W    = $clog2(STEP_MAX);
  localparam int ADDR_W    = $clog2(FRAME_BYTES);
  localparam int RX_CNT_W  = $clog2(FRAME_BYTES + 1);
  localparam int STG_W     = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 88;

  localparam logic [7:0] CRC_POLY           = 8'h07;
  localparam logic [7:0] PUBLISH_HEADER_RST = 8'h55;
  localparam logic [7:0] ARM_HEADER_RST     = 8'h56;
  localparam logic [7:0] REPLY_HEADER_RST   = 8'hAA;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_END   = 2'd1,
    OP_STAGE = 2'd2,
    OP_RSVD  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_BYTE  = 3'd0,
    ST_PUB   = 3'd1,
    ST_ARM   = 3'd2,
    ST_BAD   = 3'd3,
    ST_SHORT = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_PUBLISH = 2'd0,
    CFG_ARM     = 2'd1,
    CFG_REPLY   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_WALK = 2'd1,
    S_EMIT = 2'd2
  } state_t;

  typedef struct packed {
    logic do_byte;
    logic do_stage;
    logic walk_start;
    logic walk_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic walk_final;
    logic emit_last;
  } sts_t;

  // one byte through the msb-first crc-8 register
  function automatic logic [7:0] crc8_byte(input logic [7:0] c_in);
    logic [7:0] c;
    c = c_in;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] reset_tx_crc();
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < FRAME_BYTES - 1; i++) begin
      c = crc8_byte(c ^ ((i == 0) ? REPLY_HEADER_RST : 8'h00));
    end
    return c;
  endfunction

  localparam logic [7:0] TX_CRC_RST = reset_tx_crc();

endpackage

`default_nettype wire

/* rtl/spi_slave_crc8_frame_exchange.sv */
// spi_slave_crc8_frame_exchange: crc-8 framed full-duplex spi slave, top level
// instantiates sscfe_ctrl and sscfe_datapath; depends on sscfe_pkg
// received byte: result in the output register next cycle; staging request: writes staging only, no result
// frame end: a walk over all FRAME_BYTES positions of the frame buffers (check and reply rebuild),
// then one result per cycle as the output is taken (PAYLOAD_BYTES results when published)
// synchronous reset: counters zero, headers to defaults, reply frame built from zero staging
`timescale 1ns / 1ps
`default_nettype none

module spi_slave_crc8_frame_exchange (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // byte_value [7:0], reply_index [11:8], zero [15:12]
  input  wire logic [sscfe_pkg::S_TDATA_W-1:0] s_tdata,
  // opcode [1:0]
  input  wire logic [1:0]                      s_tuser,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [1:0]                      cfg_index,
  input  wire logic [7:0]                      cfg_data,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // tx_byte [7:0], payload_byte [15:8], payload_index [19:16],
  // good_frames [51:20], failed_frames [83:52], zero [87:84]
  output logic [sscfe_pkg::M_TDATA_W-1:0]      m_tdata,
  // status [2:0]
  output logic [2:0]                           m_tuser,
  output logic                                 m_tlast
);

  sscfe_pkg::cmd_t cmd;
  sscfe_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  sscfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  sscfe_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

/* rtl/sscfe_ctrl.sv */
// sscfe_ctrl: transaction sequencer for byte exchange, staging, frame-end walk and result emission
// depends on sscfe_pkg
`timescale 1ns / 1ps
`default_nettype none

module sscfe_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [1:0]      s_tuser,
  input  wire sscfe_pkg::sts_t sts,
  output sscfe_pkg::cmd_t      cmd
);

  sscfe_pkg::state_t  state;
  sscfe_pkg::state_t  state_next;
  sscfe_pkg::opcode_t opcode;

  assign opcode = sscfe_pkg::opcode_t'(s_tuser);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sscfe_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    unique case (state)
      sscfe_pkg::S_IDLE: begin
        s_tready = sts.out_free;
        if (s_tvalid && sts.out_free) begin
          unique case (opcode)
            sscfe_pkg::OP_BYTE:  cmd.do_byte = 1'b1;
            sscfe_pkg::OP_STAGE: cmd.do_stage = 1'b1;
            sscfe_pkg::OP_END: begin
              cmd.walk_start = 1'b1;
              state_next     = sscfe_pkg::S_WALK;
            end
            sscfe_pkg::OP_RSVD: ;
          endcase
        end
      end
      sscfe_pkg::S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_final) begin
          state_next = sscfe_pkg::S_EMIT;
        end
      end
      sscfe_pkg::S_EMIT: begin
        cmd.emit = sts.out_free;
        if (sts.out_free && sts.emit_last) begin
          state_next = sscfe_pkg::S_IDLE;
        end
      end
      default: state_next = sscfe_pkg::S_IDLE;
    endcase
  end

  a_ready_idle_only: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (state == sscfe_pkg::S_IDLE && cmd.walk_step == 1'b0))
    else $error("input taken outside idle");
  a_walk_follows_start: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_start |=> cmd.walk_step)
    else $error("frame-end walk did not start");
  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("several commands at once");

endmodule

`default_nettype wire

/* rtl/sscfe_datapath.sv */
// sscfe_datapath: frame buffers, reply staging, crc walk, counters, config and output register
// depends on sscfe_pkg; driven by sscfe_ctrl commands
`timescale 1ns / 1ps
`default_nettype none

module sscfe_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [sscfe_pkg::S_TDATA_W-1:0] s_tdata,
  input  wire logic                            cfg_valid,
  input  wire logic [1:0]                      cfg_index,
  input  wire logic [7:0]                      cfg_data,
  input  wire sscfe_pkg::cmd_t                 cmd,
  output sscfe_pkg::sts_t                      sts,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [sscfe_pkg::M_TDATA_W-1:0]      m_tdata,
  output logic [2:0]                           m_tuser,
  output logic                                 m_tlast
);

  localparam int STEP_W   = sscfe_pkg::STEP_W;
  localparam int ADDR_W   = sscfe_pkg::ADDR_W;
  localparam int RX_CNT_W = sscfe_pkg::RX_CNT_W;
  localparam int STG_W    = sscfe_pkg::STG_W;
  localparam int FRAME_B  = sscfe_pkg::FRAME_BYTES;
  localparam int PAYLD_B  = sscfe_pkg::PAYLOAD_BYTES;

  logic [7:0] rx_mem  [FRAME_B];
  logic [7:0] tx_mem  [FRAME_B];
  logic [7:0] stg_mem [PAYLD_B];

  logic [RX_CNT_W-1:0] rx_count;
  logic [STEP_W-1:0]   step;
  logic [7:0]          crc_rx;
  logic [7:0]          crc_tx;
  logic [7:0]          frame_hdr;
  sscfe_pkg::status_t  verdict;
  logic [31:0]         good_count;
  logic [31:0]         fail_count;
  logic [7:0]          pub_hdr;
  logic [7:0]          arm_hdr;
  logic [7:0]          rep_hdr;

  logic                out_valid;
  logic [7:0]          out_tx;
  sscfe_pkg::status_t  out_status;
  logic [7:0]          out_pb;
  logic [3:0]          out_pi;
  logic                out_last;
  logic [31:0]         out_good;
  logic [31:0]         out_fail;

  logic [7:0]          in_byte;
  logic [3:0]          in_ridx;
  logic                rx_open;
  logic [STEP_W:0]     rd_pos;
  logic                rd_ok;
  logic [7:0]          rx_rd;
  logic [STEP_W:0]     stg_pos;
  logic                stg_ok;
  logic [7:0]          bld_byte;
  logic                step_final;
  logic                crc_ok;
  sscfe_pkg::status_t  frame_verdict;
  logic                out_free;
  logic                emit_last;

  assign in_byte    = s_tdata[7:0];
  assign in_ridx    = s_tdata[11:8];
  assign rx_open    = rx_count < RX_CNT_W'(FRAME_B);
  assign rd_pos     = cmd.emit ? ({1'b0, step} + (STEP_W + 1)'(1)) : {1'b0, step};
  assign rd_ok      = rd_pos < (STEP_W + 1)'(FRAME_B);
  assign rx_rd      = rx_mem[rd_pos[ADDR_W-1:0]];
  assign stg_pos    = {1'b0, step} - (STEP_W + 1)'(1);
  assign stg_ok     = (step != '0) && (stg_pos < (STEP_W + 1)'(PAYLD_B));
  assign step_final = step == STEP_W'(FRAME_B - 1);
  assign crc_ok     = crc_rx == rx_rd;
  assign out_free   = !out_valid || m_tready;
  assign emit_last  = (verdict != sscfe_pkg::ST_PUB) || (step == STEP_W'(PAYLD_B - 1));

  always_comb begin
    if (step == '0) begin
      bld_byte = rep_hdr;
    end else if (stg_ok) begin
      bld_byte = stg_mem[stg_pos[STG_W-1:0]];
    end else begin
      bld_byte = 8'h00;
    end
  end

  always_comb begin
    priority if (rx_open) begin
      frame_verdict = sscfe_pkg::ST_SHORT;
    end else if (crc_ok && frame_hdr == pub_hdr) begin
      frame_verdict = sscfe_pkg::ST_PUB;
    end else if (crc_ok && frame_hdr == arm_hdr) begin
      frame_verdict = sscfe_pkg::ST_ARM;
    end else begin
      frame_verdict = sscfe_pkg::ST_BAD;
    end
  end

  assign sts.out_free   = out_free;
  assign sts.walk_final = step_final;
  assign sts.emit_last  = emit_last;

  // received frame: no reset; a short frame is walked too, but its verdict is then short
  always_ff @(posedge clk) begin
    if (cmd.do_byte && rx_open) begin
      rx_mem[rx_count[ADDR_W-1:0]] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_count   <= '0;
      step       <= '0;
      crc_rx     <= 8'h00;
      crc_tx     <= 8'h00;
      verdict    <= sscfe_pkg::ST_BYTE;
      good_count <= '0;
      fail_count <= '0;
      pub_hdr    <= sscfe_pkg::PUBLISH_HEADER_RST;
      arm_hdr    <= sscfe_pkg::ARM_HEADER_RST;
      rep_hdr    <= sscfe_pkg::REPLY_HEADER_RST;
      out_valid  <= 1'b0;
      for (int i = 0; i < PAYLD_B; i++) begin
        stg_mem[i] <= 8'h00;
      end
      for (int i = 0; i < FRAME_B; i++) begin
        tx_mem[i] <= (i == 0) ? sscfe_pkg::REPLY_HEADER_RST :
                     (i == FRAME_B - 1) ? sscfe_pkg::TX_CRC_RST : 8'h00;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          sscfe_pkg::CFG_PUBLISH: pub_hdr <= cfg_data;
          sscfe_pkg::CFG_ARM:     arm_hdr <= cfg_data;
          sscfe_pkg::CFG_REPLY:   rep_hdr <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.do_stage && int'(in_ridx) < PAYLD_B) begin
        stg_mem[STG_W'(in_ridx)] <= in_byte;
      end

      if (cmd.do_byte) begin
        if (rx_open) begin
          rx_count <= rx_count + RX_CNT_W'(1);
        end
        out_tx     <= rx_open ? tx_mem[rx_count[ADDR_W-1:0]] : 8'h00;
        out_status <= sscfe_pkg::ST_BYTE;
        out_pb     <= 8'h00;
        out_pi     <= 4'h0;
        out_last   <= 1'b1;
        out_good   <= good_count;
        out_fail   <= fail_count;
      end

      if (cmd.walk_start) begin
        step   <= '0;
        crc_rx <= 8'h00;
        crc_tx <= 8'h00;
      end

      // check the received frame and rebuild the reply in one pass
      if (cmd.walk_step) begin
        if (step == '0) begin
          frame_hdr <= rx_rd;
        end
        if (step_final) begin
          tx_mem[step[ADDR_W-1:0]] <= crc_tx;
          step     <= '0;
          rx_count <= '0;
          verdict  <= frame_verdict;
          if (frame_verdict == sscfe_pkg::ST_PUB) begin
            good_count <= good_count + 32'd1;
          end else if (frame_verdict != sscfe_pkg::ST_ARM) begin
            fail_count <= fail_count + 32'd1;
          end
        end else begin
          tx_mem[step[ADDR_W-1:0]] <= bld_byte;
          crc_rx <= sscfe_pkg::crc8_byte(crc_rx ^ rx_rd);
          crc_tx <= sscfe_pkg::crc8_byte(crc_tx ^ bld_byte);
          step   <= step + STEP_W'(1);
        end
      end

      if (cmd.emit) begin
        out_tx     <= 8'h00;
        out_status <= verdict;
        out_pb     <= (verdict == sscfe_pkg::ST_PUB && rd_ok) ? rx_rd : 8'h00;
        out_pi     <= (verdict == sscfe_pkg::ST_PUB) ? step[3:0] : 4'h0;
        out_last   <= emit_last;
        out_good   <= good_count;
        out_fail   <= fail_count;
        step       <= step + STEP_W'(1);
      end

      if (cmd.do_byte || cmd.emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;
  assign m_tdata  = {4'h0, out_fail, out_good, out_pi, out_pb, out_tx};

  a_rx_bound: assert property (@(posedge clk) disable iff (rst)
    rx_count <= RX_CNT_W'(FRAME_B))
    else $error("receive count beyond frame length");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.do_byte || cmd.emit) |-> out_free)
    else $error("output register overwritten before transaction");
  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.walk_step && step_final) |=> (rx_count == '0 && step == '0))
    else $error("frame end did not restart reception");

endmodule

`default_nettype wire
